FILE: rtl/dpg_pkg.sv
`default_nettype none

package dpg_pkg;

  // Field widths
  localparam int CMD_W   = 2;
  localparam int IDX_W   = 8;
  localparam int ADDR_W  = 32;
  localparam int PC_W    = 8;
  localparam int BPP_W   = 12;
  localparam int OFF_W   = 20;
  localparam int BLK_W   = 4;
  localparam int WORD_W  = 32;
  localparam int CFG_IDX_W = 2;

  // Default geometry (both must be powers of two)
  localparam int DEF_PAGE_BYTES = 4096;
  localparam int DEF_MAX_PAGES  = 256;

  // Configuration reset values
  localparam logic [PC_W-1:0]   RST_PERIOD_COUNT     = 8'd2;
  localparam logic [BPP_W-1:0]  RST_BYTES_PER_PERIOD = 12'd32;
  localparam logic [ADDR_W-1:0] RST_PROGRAM_BASE     = 32'd0;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_COUNT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PERIOD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PROGRAM_BASE     = 2'd2;

  // Opcodes and sync kinds
  localparam logic [3:0] OP_WRITE = 4'h1;
  localparam logic [3:0] OP_JUMP  = 4'h7;
  localparam logic [3:0] OP_SYNC  = 4'h8;
  localparam logic [3:0] SYNC_FM1 = 4'h6;
  localparam logic [3:0] SYNC_VRO = 4'hc;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD,
    CMD_RESTART,
    CMD_NEXT
  } cmd_t;

  typedef enum logic [1:0] {
    PH_START,
    PH_WRITE,
    PH_END,
    PH_JUMP
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_OUT
  } ctl_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  function automatic logic [WORD_W-1:0] sync_word(input logic [3:0] kind);
    sync_word = {OP_SYNC, 24'd0, kind};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/dma_program_generator_unit.sv
`default_nettype none

// Capture DMA program generator for a scatter-gather ring.
// Input channel in_*: in_tuser carries the command (load page, restart,
// next instruction); in_tdata carries page_index [7:0] and page_address
// [39:8]. Each next request returns one instruction on out_*: out_tdata
// holds instruction_word [31:0] and operand_word [63:32], out_tlast marks
// the closing jump. Load and restart requests return nothing.
// cfg_we/cfg_index/cfg_wdata write period_count (0), bytes_per_period (1)
// and program_base (2); write them only while the block is idle.
// Flow: a load, restart or unused command leaves the block idle. A sync
// or jump request is built in the pending result and then moved to the
// output register. A write instruction takes its block number from a
// 4-step restoring divider, run in parallel with the page table read,
// then is built in the pending result and handed to the output register.
// in_tready is high only while no request is in progress, one at a time.
// A stalled receiver holds one result in the output register; the next
// result then waits in the block and holds further requests back.
// Reset rewinds the program to its start sync and restores the register
// defaults; the page table is not cleared and must be loaded before use.
// PAGE_BYTES and MAX_PAGES must be powers of two.
module dma_program_generator_unit
  import dpg_pkg::*;
#(
  parameter int PAGE_BYTES = DEF_PAGE_BYTES,
  parameter int MAX_PAGES  = DEF_MAX_PAGES
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  // [7:0] page_index, [39:8] page_address
  input  wire logic [39:0]          in_tdata,
  // [1:0] command
  input  wire logic [CMD_W-1:0]     in_tuser,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  // [31:0] instruction_word, [63:32] operand_word
  output logic      [63:0]          out_tdata,
  output logic                      out_tlast,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ADDR_W-1:0]    cfg_wdata
);

  localparam int PAGE_W   = $clog2(PAGE_BYTES);
  localparam int PG_IDX_W = $clog2(MAX_PAGES);
  localparam int ROOM_W   = PAGE_W + 1;
  localparam int CMP_W    = (ROOM_W > BPP_W) ? ROOM_W : BPP_W;

  // Configuration
  logic [PC_W-1:0]   period_count_r;
  logic [BPP_W-1:0]  bytes_per_period_r;
  logic [ADDR_W-1:0] program_base_r;

  // Program state
  ctl_state_t       state_r, state_nxt;
  phase_t           phase_r, phase_nxt;
  logic [PC_W-1:0]  period_index_r, period_index_nxt;
  logic [BPP_W-1:0] bytes_left_r, bytes_left_nxt;
  logic [OFF_W-1:0] byte_offset_r, byte_offset_nxt;

  // Pending result
  logic [WORD_W-1:0] res_instr_r, res_instr_nxt;
  logic [WORD_W-1:0] res_oper_r, res_oper_nxt;
  logic              res_last_r, res_last_nxt;

  // Output register
  logic        out_tvalid_r;
  logic [63:0] out_tdata_r;
  logic        out_tlast_r;
  logic        out_free;

  logic              in_fire;
  logic [IDX_W-1:0]  in_page_index;
  logic [ADDR_W-1:0] in_page_address;
  logic              idx_ok;
  logic              eff_write;

  logic              ram_we;
  logic [OFF_W-1:0]  page_num;
  logic [ADDR_W-1:0] page_base;
  logic              div_start;
  logic [BLK_W-1:0]  block;
  div_status_t       div_stat;

  // Write segment datapath
  logic [BPP_W-1:0]  wr_rest;
  logic [PAGE_W-1:0] wr_in_page;
  logic [CMP_W-1:0]  wr_room;
  logic [BPP_W-1:0]  wr_len;
  logic              wr_first;
  logic              wr_last;
  logic [BPP_W-1:0]  wr_left;
  logic [PC_W-1:0]   wr_next_period;
  logic [WORD_W-1:0] wr_instr;

  assign in_tready       = (state_r == ST_IDLE);
  assign in_fire         = in_tvalid && in_tready;
  assign in_page_index   = in_tdata[7:0];
  assign in_page_address = in_tdata[39:8];
  assign idx_ok          = (32'(in_page_index) < MAX_PAGES);
  assign eff_write       = (phase_r == PH_WRITE) && (period_index_r < period_count_r);
  assign page_num        = byte_offset_r >> PAGE_W;

  dpg_page_ram #(
    .DEPTH (MAX_PAGES)
  ) u_page_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (PG_IDX_W'(in_page_index)),
    .wdata (in_page_address),
    .raddr (page_num[PG_IDX_W-1:0]),
    .rdata (page_base)
  );

  dpg_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    (period_index_r),
    .den    (period_count_r),
    .quot   (block),
    .status (div_stat)
  );

  always_comb begin
    wr_rest    = (bytes_left_r == '0) ? bytes_per_period_r : bytes_left_r;
    wr_in_page = byte_offset_r[PAGE_W-1:0];
    wr_room    = CMP_W'(PAGE_BYTES) - CMP_W'(wr_in_page);
    wr_len     = (wr_room > CMP_W'(wr_rest)) ? wr_rest : BPP_W'(wr_room);
    wr_first   = (wr_rest == bytes_per_period_r);
    wr_last    = (wr_len == wr_rest);
    wr_left    = wr_rest - wr_len;
    wr_next_period = period_index_r + 1'b1;
    wr_instr   = {OP_WRITE, wr_first, wr_last, 1'b0, wr_last,
                  wr_first ? ~block : 4'h0, wr_first ? block : 4'h0,
                  4'h0, wr_len};
  end

  always_comb begin
    state_nxt        = state_r;
    phase_nxt        = phase_r;
    period_index_nxt = period_index_r;
    bytes_left_nxt   = bytes_left_r;
    byte_offset_nxt  = byte_offset_r;
    res_instr_nxt    = res_instr_r;
    res_oper_nxt     = res_oper_r;
    res_last_nxt     = res_last_r;
    ram_we           = 1'b0;
    div_start        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_tuser)
            CMD_LOAD: begin
              ram_we = idx_ok;
            end
            CMD_RESTART: begin
              phase_nxt        = PH_START;
              period_index_nxt = '0;
              bytes_left_nxt   = '0;
              byte_offset_nxt  = '0;
            end
            CMD_NEXT: begin
              res_oper_nxt = '0;
              res_last_nxt = 1'b0;
              state_nxt    = ST_OUT;
              if (eff_write) begin
                // block number and page base are fetched meanwhile
                div_start = 1'b1;
                state_nxt = ST_DIV;
              end else begin
                case (phase_r)
                  PH_START: begin
                    res_instr_nxt    = sync_word(SYNC_FM1);
                    period_index_nxt = '0;
                    bytes_left_nxt   = '0;
                    byte_offset_nxt  = '0;
                    phase_nxt = (period_count_r == '0) ? PH_END : PH_WRITE;
                  end
                  PH_JUMP: begin
                    res_instr_nxt    = {OP_JUMP, 28'd0};
                    res_oper_nxt     = program_base_r;
                    res_last_nxt     = 1'b1;
                    phase_nxt        = PH_START;
                    period_index_nxt = '0;
                    bytes_left_nxt   = '0;
                    byte_offset_nxt  = '0;
                  end
                  default: begin
                    // end sync, also when the periods ran out
                    res_instr_nxt = sync_word(SYNC_VRO);
                    phase_nxt     = PH_JUMP;
                  end
                endcase
              end
            end
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          res_instr_nxt   = wr_instr;
          res_oper_nxt    = page_base + ADDR_W'(wr_in_page);
          res_last_nxt    = 1'b0;
          byte_offset_nxt = byte_offset_r + OFF_W'(wr_len);
          bytes_left_nxt  = wr_left;
          if (wr_left == '0) begin
            period_index_nxt = wr_next_period;
            if (wr_next_period == '0 || wr_next_period >= period_count_r) begin
              phase_nxt = PH_END;
            end
          end
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      phase_r        <= PH_START;
      period_index_r <= '0;
      bytes_left_r   <= '0;
      byte_offset_r  <= '0;
    end else begin
      state_r        <= state_nxt;
      phase_r        <= phase_nxt;
      period_index_r <= period_index_nxt;
      bytes_left_r   <= bytes_left_nxt;
      byte_offset_r  <= byte_offset_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_instr_r <= res_instr_nxt;
    res_oper_r  <= res_oper_nxt;
    res_last_r  <= res_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_count_r     <= RST_PERIOD_COUNT;
      bytes_per_period_r <= RST_BYTES_PER_PERIOD;
      program_base_r     <= RST_PROGRAM_BASE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PERIOD_COUNT:     period_count_r     <= cfg_wdata[PC_W-1:0];
        REG_BYTES_PER_PERIOD: bytes_per_period_r <= cfg_wdata[BPP_W-1:0];
        REG_PROGRAM_BASE:     program_base_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Output register: load when empty or being drained
  assign out_free = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (state_r == ST_OUT && out_free) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && out_free) begin
      out_tdata_r <= {res_oper_r, res_instr_r};
      out_tlast_r <= res_last_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

`ifndef SYNTH
  a_last_is_jump: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_tlast_r) |-> (out_tdata_r[31:28] == OP_JUMP))
    else $error("last marker on an instruction other than the jump");
  a_start_rewound: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_START) |->
      (period_index_r == '0 && bytes_left_r == '0 && byte_offset_r == '0))
    else $error("start phase with a program position not rewound");
  a_next_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tuser == CMD_NEXT) |=> (state_r != ST_IDLE))
    else $error("next request produced no result");
`endif

endmodule

`default_nettype wire

FILE: rtl/dpg_div.sv
`default_nettype none

// Block number (num * 16) / den, one restoring step per cycle.
module dpg_div
  import dpg_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [PC_W-1:0]   num,
  input  wire logic [PC_W-1:0]   den,
  output logic      [BLK_W-1:0]  quot,
  output div_status_t            status
);

  localparam int CNT_W = $clog2(BLK_W);

  logic [PC_W-1:0]  rem_r;
  logic [PC_W-1:0]  rem_nxt;
  logic [BLK_W-1:0] quot_r;
  logic [BLK_W-1:0] quot_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [PC_W:0]    shifted;
  logic             take;

  // Shared compare and subtract
  always_comb begin
    shifted  = {rem_r, 1'b0};
    take     = (shifted >= {1'b0, den});
    rem_nxt  = take ? PC_W'(shifted - {1'b0, den}) : PC_W'(shifted);
    quot_nxt = {quot_r[BLK_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(BLK_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= num;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      quot_r <= quot_nxt;
    end
  end

  assign quot        = quot_r;
  assign status.busy = busy_r;
  assign status.done = done_r;

`ifndef SYNTH
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a running division");
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");
  a_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !start && cnt_r == CNT_W'(BLK_W - 1)) |=> (done_r && !busy_r))
    else $error("divider missed its last step");
`endif

endmodule

`default_nettype wire

FILE: rtl/dpg_page_ram.sv
`default_nettype none

module dpg_page_ram
  import dpg_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_PAGES
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [ADDR_W-1:0]        wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [ADDR_W-1:0]        rdata
);

  logic [ADDR_W-1:0] mem [DEPTH];
  logic [ADDR_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire
